FILE: rtl/tlpq_pkg.sv
// shared types and constants for the three-level priority queue
// used by tlpq_ctrl, tlpq_datapath and three_level_priority_queue; no dependencies
package tlpq_pkg;

   // default sizing
   localparam int CAPACITY_DEFAULT     = 16;
   localparam int PAYLOAD_BITS_DEFAULT = 32;

   // fixed field widths of the ports
   localparam int MODE_W     = 3;
   localparam int LEVEL_W    = 2;
   localparam int WORD_W     = 32;
   localparam int POSITION_W = 4;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 5;
   localparam int LANES      = 3;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_ENQUEUE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DEQUEUE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PURGE   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FRONT   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REAR    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd5;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd6;

   // priority levels
   localparam logic [LEVEL_W-1:0] LEVEL_LOW    = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_HIGH   = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_EXTRA  = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_PEEK = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

   // commands from controller to datapath
   typedef struct packed {
      logic load_req;   // capture the accepted transaction
      logic exec;       // update lanes and access the entry memory
      logic load_rsp;   // move the finished result into the output register
   } cmd_type;

endpackage

FILE: rtl/tlpq_ctrl.sv
// controller state machine for the three-level priority queue
// depends on tlpq_pkg; drives the datapath through tlpq_pkg::cmd_type
module tlpq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tlpq_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   // output register can take a new result this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && out_free);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load_req = accept;
   assign cmd.exec     = (state_ff == ST_EXEC);
   assign cmd.load_rsp = (state_ff == ST_DONE) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = accept ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/tlpq_datapath.sv
// datapath of the three-level priority queue: lane heads and counts, entry memory
// and result registers; depends on tlpq_pkg, commanded by tlpq_ctrl
module tlpq_datapath #(
   parameter int CAPACITY     = tlpq_pkg::CAPACITY_DEFAULT,
   parameter int PAYLOAD_BITS = tlpq_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tlpq_pkg::cmd_type               cmd,
   input  logic [tlpq_pkg::MODE_W-1:0]     req_mode,
   input  logic [tlpq_pkg::LEVEL_W-1:0]    req_level,
   input  logic [tlpq_pkg::WORD_W-1:0]     req_payload,
   input  logic [tlpq_pkg::POSITION_W-1:0] req_position,
   output logic [tlpq_pkg::WORD_W-1:0]     rsp_read_payload,
   output logic [tlpq_pkg::LEVEL_W-1:0]    rsp_read_level,
   output logic [tlpq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [tlpq_pkg::OCC_W-1:0]      rsp_occupancy
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int HELD_W = CNT_W + 2;
   localparam int CMP_W  = (HELD_W > tlpq_pkg::POSITION_W) ? HELD_W : tlpq_pkg::POSITION_W;
   localparam int DEPTH  = tlpq_pkg::LANES * CAPACITY;
   localparam int ADDR_W = $clog2(DEPTH);

   // captured transaction
   logic [tlpq_pkg::MODE_W-1:0]     req_mode_ff;
   logic [tlpq_pkg::LEVEL_W-1:0]    req_level_ff;
   logic [tlpq_pkg::WORD_W-1:0]     req_payload_ff;
   logic [tlpq_pkg::POSITION_W-1:0] req_position_ff;

   // lane state
   logic [CNT_W-1:0] counts_ff [tlpq_pkg::LANES];
   logic [CNT_W-1:0] counts_in [tlpq_pkg::LANES];
   logic [IDX_W-1:0] heads_ff  [tlpq_pkg::LANES];
   logic [IDX_W-1:0] heads_in  [tlpq_pkg::LANES];

   // entry memory
   logic [PAYLOAD_BITS-1:0] mem [DEPTH];
   logic [PAYLOAD_BITS-1:0] mem_q_ff;

   // pending result from the execute cycle
   logic [tlpq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          hit_ff, hit_in;
   logic [tlpq_pkg::LEVEL_W-1:0]  rd_level_ff, rd_level_in;

   // output register
   logic [tlpq_pkg::WORD_W-1:0]   rsp_read_payload_ff;
   logic [tlpq_pkg::LEVEL_W-1:0]  rsp_read_level_ff;
   logic [tlpq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [tlpq_pkg::OCC_W-1:0]    rsp_occupancy_ff;

   logic [tlpq_pkg::LEVEL_W-1:0] lane, top_lane, bot_lane, peek_lane, acc_lane;
   logic [HELD_W-1:0]            held;
   logic [CMP_W-1:0]             held_x, pos_x, pos_m, pos_l;
   logic [CMP_W-1:0]             cnt_x [tlpq_pkg::LANES];
   logic [CMP_W-1:0]             peek_off;
   logic [IDX_W-1:0]             acc_off;
   logic [IDX_W:0]               wrap_sum;
   logic [IDX_W-1:0]             acc_idx;
   logic [ADDR_W-1:0]            acc_addr;
   logic                         mem_we, mem_re;
   logic [63:0]                  wr_wide, rd_wide;

   always_comb begin
      lane = (req_level_ff == tlpq_pkg::LEVEL_EXTRA) ? tlpq_pkg::LEVEL_HIGH : req_level_ff;

      held = HELD_W'(counts_ff[0]) + HELD_W'(counts_ff[1]) + HELD_W'(counts_ff[2]);
      held_x = CMP_W'(held);
      for (int l = 0; l < tlpq_pkg::LANES; l++) begin
         cnt_x[l] = CMP_W'(counts_ff[l]);
      end

      // oldest entry sits in the highest non-empty lane, newest in the lowest
      if (counts_ff[2] != '0)      top_lane = tlpq_pkg::LEVEL_HIGH;
      else if (counts_ff[1] != '0) top_lane = tlpq_pkg::LEVEL_MEDIUM;
      else                         top_lane = tlpq_pkg::LEVEL_LOW;
      if (counts_ff[0] != '0)      bot_lane = tlpq_pkg::LEVEL_LOW;
      else if (counts_ff[1] != '0) bot_lane = tlpq_pkg::LEVEL_MEDIUM;
      else                         bot_lane = tlpq_pkg::LEVEL_HIGH;

      // peek walks high, then medium, then low
      pos_x = CMP_W'(req_position_ff);
      pos_m = pos_x - cnt_x[2];
      pos_l = pos_m - cnt_x[1];
      if (pos_x < cnt_x[2]) begin
         peek_lane = tlpq_pkg::LEVEL_HIGH;
         peek_off  = pos_x;
      end else if (pos_m < cnt_x[1]) begin
         peek_lane = tlpq_pkg::LEVEL_MEDIUM;
         peek_off  = pos_m;
      end else begin
         peek_lane = tlpq_pkg::LEVEL_LOW;
         peek_off  = pos_l;
      end

      for (int l = 0; l < tlpq_pkg::LANES; l++) begin
         counts_in[l] = counts_ff[l];
         heads_in[l]  = heads_ff[l];
      end
      status_in   = tlpq_pkg::STATUS_OK;
      hit_in      = 1'b0;
      rd_level_in = tlpq_pkg::LEVEL_LOW;
      acc_lane    = lane;
      acc_off     = '0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;

      case (req_mode_ff)
         tlpq_pkg::MODE_ENQUEUE: begin
            acc_off = counts_ff[lane][IDX_W-1:0];
            if (held >= HELD_W'(CAPACITY)) begin
               status_in = tlpq_pkg::STATUS_FULL;
            end else begin
               mem_we          = cmd.exec;
               counts_in[lane] = counts_ff[lane] + CNT_W'(1);
            end
         end
         tlpq_pkg::MODE_DEQUEUE: begin
            acc_lane = top_lane;
            acc_off  = IDX_W'(1);
            if (held == '0) begin
               status_in = tlpq_pkg::STATUS_EMPTY;
            end else begin
               counts_in[top_lane] = counts_ff[top_lane] - CNT_W'(1);
            end
         end
         tlpq_pkg::MODE_PURGE: begin
            if (held == '0) begin
               status_in = tlpq_pkg::STATUS_EMPTY;
            end else begin
               counts_in[lane] = '0;
               heads_in[lane]  = '0;
            end
         end
         tlpq_pkg::MODE_FRONT: begin
            acc_lane = top_lane;
            if (held == '0) begin
               status_in = tlpq_pkg::STATUS_EMPTY;
            end else begin
               mem_re      = cmd.exec;
               hit_in      = 1'b1;
               rd_level_in = top_lane;
            end
         end
         tlpq_pkg::MODE_REAR: begin
            acc_lane = bot_lane;
            acc_off  = IDX_W'(counts_ff[bot_lane] - CNT_W'(1));
            if (held == '0) begin
               status_in = tlpq_pkg::STATUS_EMPTY;
            end else begin
               mem_re      = cmd.exec;
               hit_in      = 1'b1;
               rd_level_in = bot_lane;
            end
         end
         tlpq_pkg::MODE_PEEK: begin
            acc_lane = peek_lane;
            acc_off  = peek_off[IDX_W-1:0];
            if (pos_x >= held_x) begin
               status_in = tlpq_pkg::STATUS_BAD_PEEK;
            end else begin
               mem_re      = cmd.exec;
               hit_in      = 1'b1;
               rd_level_in = peek_lane;
            end
         end
         tlpq_pkg::MODE_CLEAR: begin
            for (int l = 0; l < tlpq_pkg::LANES; l++) begin
               counts_in[l] = '0;
               heads_in[l]  = '0;
            end
         end
         default: begin
         end
      endcase

      // circular index within the lane: both terms stay below the capacity
      wrap_sum = {1'b0, heads_ff[acc_lane]} + {1'b0, acc_off};
      if (wrap_sum >= (IDX_W + 1)'(CAPACITY)) begin
         acc_idx = IDX_W'(wrap_sum - (IDX_W + 1)'(CAPACITY));
      end else begin
         acc_idx = wrap_sum[IDX_W-1:0];
      end
      acc_addr = ADDR_W'(acc_lane) * ADDR_W'(CAPACITY) + ADDR_W'(acc_idx);

      // dequeue moves the head of the front lane one entry on
      if ((req_mode_ff == tlpq_pkg::MODE_DEQUEUE) && (held != '0)) begin
         heads_in[top_lane] = acc_idx;
      end

      wr_wide = 64'(req_payload_ff);
      rd_wide = 64'(mem_q_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_mode_ff     <= req_mode;
         req_level_ff    <= req_level;
         req_payload_ff  <= req_payload;
         req_position_ff <= req_position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < tlpq_pkg::LANES; l++) begin
            counts_ff[l] <= '0;
            heads_ff[l]  <= '0;
         end
      end else if (cmd.exec) begin
         for (int l = 0; l < tlpq_pkg::LANES; l++) begin
            counts_ff[l] <= counts_in[l];
            heads_ff[l]  <= heads_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[acc_addr] <= wr_wide[PAYLOAD_BITS-1:0];
      end
      if (mem_re) begin
         mem_q_ff <= mem[acc_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff   <= status_in;
         hit_ff      <= hit_in;
         rd_level_ff <= rd_level_in;
      end
   end

   // lane counts are already updated when the result is loaded
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_read_payload_ff <= hit_ff ? rd_wide[tlpq_pkg::WORD_W-1:0] : '0;
         rsp_read_level_ff   <= rd_level_ff;
         rsp_status_ff       <= status_ff;
         rsp_occupancy_ff    <= tlpq_pkg::OCC_W'(held);
      end
   end

   assign rsp_read_payload = rsp_read_payload_ff;
   assign rsp_read_level   = rsp_read_level_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_occupancy    = rsp_occupancy_ff;

endmodule

FILE: rtl/three_level_priority_queue.sv
// Three-level priority queue: entries wait in FIFO order in one of three lanes (high,
// medium, low) sharing CAPACITY slots; the front is the oldest entry of the highest
// non-empty lane. Each accepted transaction gives exactly one result with a status and
// the occupancy after the operation. A transaction executes in ST_EXEC against the lane
// counters and the synchronous entry memory; in ST_DONE the registered memory read then
// lands in the output register once that register is free. A new request is taken in
// ST_IDLE, or in ST_DONE as the result is loaded, never while one executes; a result
// may wait in the output register while the next request is already captured.
// Depends on tlpq_pkg, tlpq_ctrl and tlpq_datapath.
module three_level_priority_queue #(
   parameter int CAPACITY     = tlpq_pkg::CAPACITY_DEFAULT,
   parameter int PAYLOAD_BITS = tlpq_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tlpq_pkg::MODE_W-1:0]     req_mode,
   input  logic [tlpq_pkg::LEVEL_W-1:0]    req_level,
   input  logic [tlpq_pkg::WORD_W-1:0]     req_payload,
   input  logic [tlpq_pkg::POSITION_W-1:0] req_position,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tlpq_pkg::WORD_W-1:0]     rsp_read_payload,
   output logic [tlpq_pkg::LEVEL_W-1:0]    rsp_read_level,
   output logic [tlpq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [tlpq_pkg::OCC_W-1:0]      rsp_occupancy
);

   tlpq_pkg::cmd_type cmd;

   tlpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   tlpq_datapath #(
      .CAPACITY     (CAPACITY),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_mode         (req_mode),
      .req_level        (req_level),
      .req_payload      (req_payload),
      .req_position     (req_position),
      .rsp_read_payload (rsp_read_payload),
      .rsp_read_level   (rsp_read_level),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy)
   );

endmodule
